// ===== rtl/core/rrfs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrfs_pkg
// Shared types and constants of the round-robin failover selector.
// ----------------------------------------------------------------------------
package rrfs_pkg;

  localparam int NOW_W     = 32;
  localparam int HOLDOFF_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int MASK_W    = 16;
  localparam int HIDX_W    = 4;
  localparam int HCNT_W    = 5;

  localparam logic REQ_SUBMIT  = 1'b0;
  localparam logic REQ_REFUSED = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_RR_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_HOLDOFF = 2'd2;

  typedef struct packed {
    logic [NOW_W-1:0]     now;
    logic [NOW_W-1:0]     stamp;
    logic [HOLDOFF_W-1:0] holdoff;
  } age_req_t;

endpackage

// ===== rtl/core/rrfs_ram.sv =====
// ----------------------------------------------------------------------------
// rrfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/core/rrfs_age_cmp.sv =====
// ----------------------------------------------------------------------------
// rrfs_age_cmp
// Shared age unit: elapsed time since a down stamp against the holdoff.
// ----------------------------------------------------------------------------
module rrfs_age_cmp
  import rrfs_pkg::*;
(
  input  age_req_t req,
  output logic     expired
);

  logic [NOW_W-1:0] age;

  assign age     = req.now - req.stamp;
  assign expired = (age >= NOW_W'(req.holdoff));

endmodule

// ===== rtl/core/round_robin_failover_selector.sv =====
// ----------------------------------------------------------------------------
// round_robin_failover_selector
// Picks the primary host and the copy mask for each submitted message.
//
// Requests transfer on start while busy is low. A refused-connection report
// is absorbed at the accepting edge and gives no result; a broadcast submit
// (round robin off) gives its result in the cycle after acceptance. A round-robin
// submit scans hosts from the rotating pointer, one host per cycle, holding busy
// high until a host is up or past its holdoff or N hosts were looked at, N being
// host_count held to 1..MAX_HOST_COUNT; the result follows in the cycle after the
// last host looked at. The scan rate is set by the single timestamp RAM read port
// and the one shared age compare unit, which between them examine one host each
// cycle.
// Each result stands on the out_ ports for one cycle, flagged by out_valid;
// the receiver cannot stall. A new request may transfer in the cycle the
// result is shown. Reset clears the down flags, the pointer and the
// registers (round robin off, one host, holdoff of ten seconds). Down
// timestamps need no clearing: one counts only while its flag is set.
// ----------------------------------------------------------------------------
module round_robin_failover_selector
  import rrfs_pkg::*;
#(
  parameter int MAX_HOST_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_req_type,
  input  logic [HIDX_W-1:0]    in_host_index,
  input  logic [NOW_W-1:0]     in_now_seconds,
  output logic                 out_valid,
  output logic                 out_primary_valid,
  output logic [HIDX_W-1:0]    out_primary_host,
  output logic [MASK_W-1:0]    out_copy_mask,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int HW = (MAX_HOST_COUNT > 1) ? $clog2(MAX_HOST_COUNT) : 1;
  localparam int CW = $clog2(MAX_HOST_COUNT + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                      state_r, state_nxt;
  logic                      rr_enable_r;
  logic [HCNT_W-1:0]         host_count_r;
  logic [HOLDOFF_W-1:0]      retry_holdoff_r;
  logic [MAX_HOST_COUNT-1:0] host_down_r, host_down_nxt;
  logic [HW-1:0]             next_target_r, next_target_nxt;
  logic [HW-1:0]             t_r, t_nxt;
  logic [HW-1:0]             checked_r, checked_nxt;
  logic [NOW_W-1:0]          now_r, now_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_pv_r, out_pv_nxt;
  logic [HIDX_W-1:0]         out_ph_r, out_ph_nxt;
  logic [MASK_W-1:0]         out_mask_r, out_mask_nxt;

  logic [CW-1:0]             n_eff;
  logic [MAX_HOST_COUNT-1:0] use_mask;
  logic                      acc;
  logic                      idx_ok;
  logic [HW-1:0]             idx_h;
  logic [HW-1:0]             start_t;
  logic [HW-1:0]             t_inc, t_inc2;
  logic                      last_host;
  logic                      hit;
  logic                      ram_we;
  logic [NOW_W-1:0]          stamp;
  age_req_t                  age_req;
  logic                      age_ok;

  function automatic logic [HW-1:0] wrap_inc(input logic [HW-1:0] v, input logic [CW-1:0] n);
    logic [HW-1:0] r;
    if (32'(v) + 32'd1 >= 32'(n)) begin
      r = '0;
    end else begin
      r = HW'(32'(v) + 32'd1);
    end
    return r;
  endfunction

  always_comb begin
    if (host_count_r == '0) begin
      n_eff = CW'(1);
    end else if (32'(host_count_r) > MAX_HOST_COUNT) begin
      n_eff = CW'(MAX_HOST_COUNT);
    end else begin
      n_eff = CW'(host_count_r);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_HOST_COUNT; i++) begin
      use_mask[i] = (i < 32'(n_eff));
    end
  end

  assign busy      = (state_r == ST_SCAN);
  assign acc       = start && !busy;
  assign idx_ok    = (32'(in_host_index) < 32'(n_eff));
  assign idx_h     = HW'(in_host_index);
  assign start_t   = (32'(next_target_r) < 32'(n_eff)) ? next_target_r : '0;
  assign t_inc     = wrap_inc(t_r, n_eff);
  assign t_inc2    = wrap_inc(t_inc, n_eff);
  assign last_host = (32'(checked_r) + 32'd1 >= 32'(n_eff));
  assign ram_we    = acc && (in_req_type == REQ_REFUSED) && rr_enable_r && idx_ok;

  rrfs_ram #(
    .WIDTH (NOW_W),
    .DEPTH (MAX_HOST_COUNT)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_h),
    .wdata (in_now_seconds),
    .raddr (t_nxt),
    .rdata (stamp)
  );

  assign age_req.now     = now_r;
  assign age_req.stamp   = stamp;
  assign age_req.holdoff = retry_holdoff_r;

  rrfs_age_cmp u_age_cmp (
    .req     (age_req),
    .expired (age_ok)
  );

  assign hit = !host_down_r[t_r] || age_ok;

  always_comb begin
    state_nxt       = state_r;
    host_down_nxt   = host_down_r;
    next_target_nxt = next_target_r;
    t_nxt           = t_r;
    checked_nxt     = checked_r;
    now_nxt         = now_r;
    out_valid_nxt   = 1'b0;
    out_pv_nxt      = out_pv_r;
    out_ph_nxt      = out_ph_r;
    out_mask_nxt    = out_mask_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_req_type == REQ_REFUSED) begin
            if (rr_enable_r && idx_ok) begin
              host_down_nxt[idx_h] = 1'b1;
            end
          end else if (!rr_enable_r) begin
            out_valid_nxt = 1'b1;
            out_pv_nxt    = 1'b0;
            out_ph_nxt    = '0;
            out_mask_nxt  = MASK_W'(use_mask);
          end else begin
            t_nxt       = start_t;
            checked_nxt = '0;
            now_nxt     = in_now_seconds;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          host_down_nxt[t_r] = 1'b0;
          out_valid_nxt      = 1'b1;
          out_pv_nxt         = 1'b1;
          out_ph_nxt         = HIDX_W'(t_r);
          out_mask_nxt       = MASK_W'(host_down_nxt & use_mask);
          next_target_nxt    = t_inc;
          state_nxt          = ST_IDLE;
        end else if (last_host) begin
          out_valid_nxt   = 1'b1;
          out_pv_nxt      = 1'b0;
          out_ph_nxt      = '0;
          out_mask_nxt    = MASK_W'(host_down_r & use_mask);
          next_target_nxt = t_inc2;
          state_nxt       = ST_IDLE;
        end else begin
          t_nxt       = t_inc;
          checked_nxt = HW'(32'(checked_r) + 32'd1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      rr_enable_r     <= 1'b0;
      host_count_r    <= HCNT_W'(1);
      retry_holdoff_r <= HOLDOFF_W'(10);
      host_down_r     <= '0;
      next_target_r   <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      host_down_r   <= host_down_nxt;
      next_target_r <= next_target_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_RR_ENABLE:     rr_enable_r     <= cfg_wdata[0];
          CFG_HOST_COUNT:    host_count_r    <= cfg_wdata[HCNT_W-1:0];
          CFG_RETRY_HOLDOFF: retry_holdoff_r <= cfg_wdata[HOLDOFF_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    checked_r  <= checked_nxt;
    now_r      <= now_nxt;
    out_pv_r   <= out_pv_nxt;
    out_ph_r   <= out_ph_nxt;
    out_mask_r <= out_mask_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_primary_valid = out_pv_r;
  assign out_primary_host  = out_ph_r;
  assign out_copy_mask     = out_mask_r;

  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (32'(checked_r) < 32'(n_eff)))
    else $error("scan ran past the host count");

  a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (32'(t_r) < 32'(n_eff)))
    else $error("scan pointer beyond host count");

  a_primary_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_primary_valid) |-> $past(state_r == ST_SCAN))
    else $error("primary reported without a scan");

  a_submit_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_req_type == REQ_SUBMIT) && rr_enable_r) |=> (state_r == ST_SCAN))
    else $error("round-robin submit did not start a scan");

endmodule

// ===== tb/sv/rrfs_route_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rrfs_route_checker
// Watches the request, result and register ports of the failover selector.
// Keeps its own copy of the host flags, down stamps, pointer and registers,
// works out the routing of every accepted submit and compares each result
// strobe, field by field, with the oldest routing still due.
// ----------------------------------------------------------------------------
module rrfs_route_checker
  import rrfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 in_req_type,
  input  logic [HIDX_W-1:0]    in_host_index,
  input  logic [NOW_W-1:0]     in_now_seconds,
  input  logic                 out_valid,
  input  logic                 out_primary_valid,
  input  logic [HIDX_W-1:0]    out_primary_host,
  input  logic [MASK_W-1:0]    out_copy_mask,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output int                   fail_count,
  output int                   routes_waiting
);

  localparam int HOSTS = 16;

  typedef struct packed {
    logic              primary_valid;
    logic [HIDX_W-1:0] primary_host;
    logic [MASK_W-1:0] copy_mask;
  } route_t;

  logic                 rr_on;
  logic [HCNT_W-1:0]    host_cnt;
  logic [HOLDOFF_W-1:0] holdoff;
  logic [HOSTS-1:0]     host_down;
  logic [NOW_W-1:0]     down_stamp [HOSTS];
  int unsigned          rotor;
  route_t               routes_due [$];
  int                   n_fail = 0;

  assign fail_count = n_fail;

  function automatic int unsigned hosts_in_use();
    if (host_cnt == '0) return 1;
    if (host_cnt > HOSTS) return HOSTS;
    return 32'(host_cnt);
  endfunction

  task automatic route_submit(input logic [NOW_W-1:0] now, output route_t r);
    int unsigned n;
    int unsigned t;
    int unsigned checked;
    int unsigned i;
    logic [NOW_W-1:0] age;
    bit found;
    n = hosts_in_use();
    r = '0;
    found = 1'b0;
    if (!rr_on) begin
      for (i = 0; i < n; i++) r.copy_mask[i] = 1'b1;
      return;
    end
    t = (rotor < n) ? rotor : 0;
    checked = 0;
    while (checked < n && !found) begin
      age = now - down_stamp[t];
      if (!host_down[t]) begin
        found = 1'b1;
      end else if (age >= {16'd0, holdoff}) begin
        host_down[t] = 1'b0;
        found = 1'b1;
      end else begin
        t = (t + 1) % n;
        checked++;
      end
    end
    for (i = 0; i < n; i++) r.copy_mask[i] = host_down[i];
    r.primary_valid = found;
    r.primary_host  = found ? t[HIDX_W-1:0] : '0;
    rotor = (t + 1) % n;
  endtask

  always @(posedge clk) begin
    route_t want;
    if (!rst_n) begin
      rr_on     = 1'b0;
      host_cnt  = 5'd1;
      holdoff   = 16'd10;
      host_down = '0;
      rotor     = 0;
      for (int i = 0; i < HOSTS; i++) down_stamp[i] = '0;
      routes_due.delete();
      routes_waiting <= 0;
    end else begin
      if (out_valid) begin
        if (routes_due.size() == 0) begin
          $display("%0t: result with no submit waiting: valid %0d host %0d mask %h",
                   $time, out_primary_valid, out_primary_host, out_copy_mask);
          n_fail++;
        end else begin
          want = routes_due.pop_front();
          if (out_primary_valid !== want.primary_valid) begin
            $display("%0t: primary_valid expected %0d actual %0d",
                     $time, want.primary_valid, out_primary_valid);
            n_fail++;
          end
          if (out_primary_host !== want.primary_host) begin
            $display("%0t: primary_host expected %0d actual %0d",
                     $time, want.primary_host, out_primary_host);
            n_fail++;
          end
          if (out_copy_mask !== want.copy_mask) begin
            $display("%0t: copy_mask expected %h actual %h",
                     $time, want.copy_mask, out_copy_mask);
            n_fail++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RR_ENABLE:     rr_on    = cfg_wdata[0];
          CFG_HOST_COUNT:    host_cnt = cfg_wdata[HCNT_W-1:0];
          CFG_RETRY_HOLDOFF: holdoff  = cfg_wdata[HOLDOFF_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_req_type == REQ_REFUSED) begin
          if (rr_on && in_host_index < hosts_in_use()) begin
            host_down[in_host_index]  = 1'b1;
            down_stamp[in_host_index] = in_now_seconds;
          end
        end else begin
          route_submit(in_now_seconds, want);
          routes_due.push_back(want);
        end
      end
      routes_waiting <= routes_due.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the round-robin failover selector.
// A directed opening covers broadcast mode, refusals, retries after the
// holdoff, the all-down case, out-of-range host counts and a lowered count;
// then random phases of refusals and submits run under changing register
// settings with random sender gaps. The checker beside the block predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import rrfs_pkg::*;

  localparam int LIMIT         = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 62;

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 start          = 1'b0;
  logic                 busy;
  logic                 in_req_type    = REQ_SUBMIT;
  logic [HIDX_W-1:0]    in_host_index  = '0;
  logic [NOW_W-1:0]     in_now_seconds = '0;
  logic                 out_valid;
  logic                 out_primary_valid;
  logic [HIDX_W-1:0]    out_primary_host;
  logic [MASK_W-1:0]    out_copy_mask;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = CFG_RR_ENABLE;
  logic [CFG_DAT_W-1:0] cfg_wdata      = '0;

  int                   fail_count;
  int                   routes_waiting;
  int                   cycle_cnt      = 0;
  bit                   idle_on        = 1'b1;
  int unsigned          cur_hosts      = 1;
  int unsigned          cur_hold       = 10;
  logic [NOW_W-1:0]     clock_s;

  round_robin_failover_selector i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_host_index     (in_host_index),
    .in_now_seconds    (in_now_seconds),
    .out_valid         (out_valid),
    .out_primary_valid (out_primary_valid),
    .out_primary_host  (out_primary_host),
    .out_copy_mask     (out_copy_mask),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  rrfs_route_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_host_index     (in_host_index),
    .in_now_seconds    (in_now_seconds),
    .out_valid         (out_valid),
    .out_primary_valid (out_primary_valid),
    .out_primary_host  (out_primary_host),
    .out_copy_mask     (out_copy_mask),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .routes_waiting    (routes_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("round_robin_failover_selector: mismatch");
      $finish;
    end
  end

  task automatic send(input logic req, input logic [HIDX_W-1:0] idx,
                      input logic [NOW_W-1:0] now);
    while (idle_on && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_req_type    <= req;
    in_host_index  <= idx;
    in_now_seconds <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off until every routing has come and the block is quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (routes_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic configure(input logic rr, input logic [HCNT_W-1:0] cnt,
                           input logic [HOLDOFF_W-1:0] hold);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RR_ENABLE;
    cfg_wdata <= {{(CFG_DAT_W-1){1'b0}}, rr};
    @(posedge clk);
    cfg_index <= CFG_HOST_COUNT;
    cfg_wdata <= {{(CFG_DAT_W-HCNT_W){1'b0}}, cnt};
    @(posedge clk);
    cfg_index <= CFG_RETRY_HOLDOFF;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_hosts = (cnt == 0) ? 1 : (cnt > 16) ? 16 : 32'(cnt);
    cur_hold  = 32'(hold);
  endtask

  task automatic run_phase(input int items);
    int unsigned span;
    int unsigned roll;
    int k;
    logic [HIDX_W-1:0] idx;
    span = cur_hold / 4 + 2;
    for (k = 0; k < items; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send(logic'($urandom_range(0, 1)), HIDX_W'($urandom_range(0, 15)), $urandom);
      end else begin
        clock_s = clock_s + $urandom_range(0, span);
        if (roll < 45) begin
          if (roll < 12) idx = HIDX_W'($urandom_range(0, 15));
          else idx = HIDX_W'($urandom_range(0, cur_hosts - 1));
          send(REQ_REFUSED, idx, clock_s);
        end else begin
          send(REQ_SUBMIT, HIDX_W'($urandom_range(0, 15)), clock_s);
        end
      end
      if ($urandom_range(0, 79) == 0) settle();
    end
  endtask

  initial begin
    int p;
    logic rr;
    logic [HCNT_W-1:0] cnt;
    logic [HOLDOFF_W-1:0] hold;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // broadcast at reset settings; refusal ignored
    send(REQ_SUBMIT, 4'd0, 32'd0);
    send(REQ_REFUSED, 4'd0, 32'd0);
    send(REQ_SUBMIT, 4'd15, 32'hFFFF_FFFF);
    configure(1'b0, 5'd16, 16'd10);
    send(REQ_SUBMIT, 4'd3, 32'd7);

    // round robin over four hosts
    configure(1'b1, 5'd4, 16'd10);
    send(REQ_SUBMIT, 4'd0, 32'd100);
    send(REQ_REFUSED, 4'd1, 32'd100);
    send(REQ_REFUSED, 4'd2, 32'd101);
    send(REQ_REFUSED, 4'd15, 32'd101);
    send(REQ_SUBMIT, 4'd0, 32'd105);
    send(REQ_REFUSED, 4'd0, 32'd106);
    send(REQ_REFUSED, 4'd3, 32'd106);
    send(REQ_SUBMIT, 4'd0, 32'd107);
    send(REQ_SUBMIT, 4'd0, 32'd110);

    // count of zero, holdoff of zero
    configure(1'b1, 5'd0, 16'd0);
    send(REQ_REFUSED, 4'd0, 32'd5);
    send(REQ_SUBMIT, 4'd0, 32'd5);

    // count above the maximum, longest holdoff, time wrap
    configure(1'b1, 5'd31, 16'hFFFF);
    send(REQ_REFUSED, 4'd0, 32'hFFFF_FFF0);
    send(REQ_REFUSED, 4'd1, 32'hFFFF_FFF0);
    send(REQ_SUBMIT, 4'd0, 32'h0000_FFEE);
    send(REQ_SUBMIT, 4'd0, 32'h0000_FFEF);
    send(REQ_SUBMIT, 4'd0, 32'h0000_FFF0);

    // lower the count below the pointer
    configure(1'b1, 5'd2, 16'd3);
    send(REQ_SUBMIT, 4'd0, 32'h0001_0000);
    send(REQ_SUBMIT, 4'd0, 32'h0001_0001);

    for (p = 0; p < PHASES; p++) begin
      rr = (p % 4 != 3);
      case (p)
        0:       cnt = 5'd16;
        1:       cnt = 5'd0;
        2:       cnt = 5'd31;
        default: cnt = ($urandom_range(0, 3) == 0) ? HCNT_W'($urandom_range(0, 31))
                                                   : HCNT_W'($urandom_range(1, 6));
      endcase
      case (p % 4)
        0:       hold = 16'd0;
        1:       hold = 16'hFFFF;
        2:       hold = HOLDOFF_W'($urandom_range(0, 65535));
        default: hold = HOLDOFF_W'($urandom_range(1, 60));
      endcase
      configure(rr, cnt, hold);
      idle_on = (p != 5);
      clock_s = (p == 6) ? (32'hFFFF_F000 + $urandom_range(0, 4095)) : $urandom;
      run_phase(PHASE_ITEMS);
    end

    settle();
    if (fail_count == 0 && routes_waiting == 0) begin
      $display("round_robin_failover_selector: match");
    end else begin
      $display("round_robin_failover_selector: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rrfs_pkg.sv
rtl/core/rrfs_ram.sv
rtl/core/rrfs_age_cmp.sv
rtl/core/round_robin_failover_selector.sv
tb/sv/rrfs_route_checker.sv
tb/sv/tb.sv
